### src/fr2cf_pkg.sv
`default_nettype none

package fr2cf_pkg;

   // Input item modes.
   localparam logic [1:0] MODE_HEADER  = 2'd0;
   localparam logic [1:0] MODE_PAYLOAD = 2'd1;
   localparam logic [1:0] MODE_TRAILER = 2'd2;

   // Stream layout of one frame.
   localparam int HDR_LEN       = 5;
   localparam int TRAILER_BYTES = 3;

   // Kind of a queued command, decided by the front end.
   typedef enum logic [1:0] {
      CMD_HEADER,
      CMD_PAYLOAD,
      CMD_TRAILER
   } cmd_kind_type;

   // One command from the front end to the back end.
   typedef struct packed {
      cmd_kind_type          kind;
      logic [8:0]            total;
      logic [4:0][7:0]       bytes;
   } cmd_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       chunk_start;
      logic [3:0] chunk_dlc;
      logic       chunk_end;
      logic       frame_end;
   } rsp_type;

   // CAN-FD DLC code for a frame length of 0 to 64 bytes.
   function automatic logic [3:0] dlc_of_len(input logic [6:0] len);
      logic [3:0] dlc;
      case (len) inside
         [7'd0:7'd8]:   dlc = len[3:0];
         [7'd9:7'd12]:  dlc = 4'd9;
         [7'd13:7'd16]: dlc = 4'd10;
         [7'd17:7'd20]: dlc = 4'd11;
         [7'd21:7'd24]: dlc = 4'd12;
         [7'd25:7'd32]: dlc = 4'd13;
         [7'd33:7'd48]: dlc = 4'd14;
         default:       dlc = 4'd15;
      endcase
      return dlc;
   endfunction

endpackage

`default_nettype wire

### src/fr2cf_queue.sv
`default_nettype none

module fr2cf_queue
   import fr2cf_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      head
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             do_push, do_pop;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = head_ff;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Two-entry queue: the head slot is always the oldest entry.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (do_push && !do_pop) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (do_pop && do_push) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

### src/fr2cf_front.sv
`default_nettype none

module fr2cf_front
   import fr2cf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [1:0]  mode,
   input  wire logic        startup_flag,
   input  wire logic        sync_flag,
   input  wire logic        null_flag,
   input  wire logic        preamble_flag,
   input  wire logic        reserved_flag,
   input  wire logic [10:0] frame_ident,
   input  wire logic [6:0]  payload_words,
   input  wire logic [10:0] header_check,
   input  wire logic [5:0]  cycle_number,
   input  wire logic [7:0]  data_byte,
   input  wire logic [23:0] trailer_check,
   output logic             cmd_push,
   output cmd_type          cmd_data
);

   logic       in_frame_ff, in_frame_in;
   logic [8:0] left_ff, left_in;
   logic [8:0] total;

   assign total = {1'b0, payload_words, 1'b0} + 9'd8;

   // Classify each accepted transaction and track how many stream bytes remain.
   always_comb begin
      in_frame_in        = in_frame_ff;
      left_in            = left_ff;
      cmd_push           = 1'b0;
      cmd_data.kind      = CMD_PAYLOAD;
      cmd_data.total     = total;
      cmd_data.bytes     = '0;
      cmd_data.bytes[0]  = data_byte;
      case (mode)
         MODE_HEADER: begin
            cmd_push          = accept;
            cmd_data.kind     = CMD_HEADER;
            cmd_data.bytes[0] = {startup_flag, sync_flag, null_flag, preamble_flag,
                                 reserved_flag, frame_ident[10:8]};
            cmd_data.bytes[1] = frame_ident[7:0];
            cmd_data.bytes[2] = {payload_words, header_check[10]};
            cmd_data.bytes[3] = header_check[9:2];
            cmd_data.bytes[4] = {header_check[1:0], cycle_number};
            if (accept) begin
               in_frame_in = 1'b1;
               left_in     = total - 9'(HDR_LEN);
            end
         end
         MODE_PAYLOAD: begin
            if (accept && in_frame_ff && left_ff > 9'(TRAILER_BYTES)) begin
               cmd_push = 1'b1;
               left_in  = left_ff - 9'd1;
            end
         end
         MODE_TRAILER: begin
            cmd_data.kind     = CMD_TRAILER;
            cmd_data.bytes[0] = trailer_check[7:0];
            cmd_data.bytes[1] = trailer_check[15:8];
            cmd_data.bytes[2] = trailer_check[23:16];
            if (accept && in_frame_ff && left_ff == 9'(TRAILER_BYTES)) begin
               cmd_push    = 1'b1;
               in_frame_in = 1'b0;
               left_in     = 9'd0;
            end
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         left_ff     <= 9'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         left_ff     <= left_in;
      end
   end

endmodule

`default_nettype wire

### src/fr2cf_back.sv
`default_nettype none

module fr2cf_back
   import fr2cf_pkg::*;
#(
   parameter int CHUNK_BYTES = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     cmd_empty,
   input  wire cmd_type  cmd_head,
   output logic          cmd_pop,
   input  wire logic     rsp_full,
   output logic          rsp_push,
   output rsp_type       rsp_data
);

   localparam int FW = $clog2(CHUNK_BYTES);
   localparam logic [FW:0] FILL_LAST = (FW + 1)'(CHUNK_BYTES - 1);

   logic [8:0]    left_ff, left_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    seq_ff, seq_in;
   logic          open_ff, open_in;
   logic          started_ff, started_in;
   logic [2:0]    sub_ff, sub_in;

   logic          fresh, fire;
   logic [8:0]    eff_left, left_next;
   logic [FW-1:0] eff_fill;
   logic [FW:0]   fill_next;
   logic [7:0]    eff_seq;
   logic          eff_open;
   logic [6:0]    chunk_len;
   logic [2:0]    last_sub;
   logic          fe, ce;

   // A header command starts a new frame and discards any unfinished one.
   assign fresh    = !cmd_empty && (cmd_head.kind == CMD_HEADER) && !started_ff;
   assign eff_left = fresh ? cmd_head.total : left_ff;
   assign eff_fill = fresh ? '0 : fill_ff;
   assign eff_seq  = fresh ? 8'd0 : seq_ff;
   assign eff_open = fresh ? 1'b0 : open_ff;
   assign fire     = !cmd_empty && !rsp_full;

   assign chunk_len = (eff_left >= 9'(CHUNK_BYTES - 1)) ? 7'(CHUNK_BYTES)
                                                        : eff_left[6:0] + 7'd1;
   assign fill_next = {1'b0, eff_fill} + (FW + 1)'(1);
   assign left_next = eff_left - 9'd1;
   assign fe        = (left_next == 9'd0);
   assign ce        = fe || (fill_next >= FILL_LAST);

   always_comb begin
      case (cmd_head.kind)
         CMD_HEADER:  last_sub = 3'(HDR_LEN - 1);
         CMD_TRAILER: last_sub = 3'(TRAILER_BYTES - 1);
         default:     last_sub = 3'd0;
      endcase
   end

   // One chunk byte per cycle when fire is set: a sequence byte when no chunk is open, else a stream byte.
   always_comb begin
      left_in     = left_ff;
      fill_in     = fill_ff;
      seq_in      = seq_ff;
      open_in     = open_ff;
      started_in  = started_ff;
      sub_in      = sub_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = '0;
      if (fire) begin
         rsp_push   = 1'b1;
         started_in = 1'b1;
         left_in    = eff_left;
         fill_in    = eff_fill;
         seq_in     = eff_seq;
         if (!eff_open) begin
            rsp_data.out_byte    = eff_seq;
            rsp_data.chunk_start = 1'b1;
            rsp_data.chunk_dlc   = dlc_of_len(chunk_len);
            open_in              = 1'b1;
         end else begin
            rsp_data.out_byte  = cmd_head.bytes[sub_ff];
            rsp_data.chunk_end = ce;
            rsp_data.frame_end = fe;
            left_in            = left_next;
            open_in            = 1'b1;
            fill_in            = fill_next[FW-1:0];
            if (ce) begin
               open_in = 1'b0;
               fill_in = '0;
               seq_in  = eff_seq + 8'd1;
            end
            if (sub_ff == last_sub) begin
               cmd_pop    = 1'b1;
               sub_in     = 3'd0;
               started_in = 1'b0;
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= 9'd0;
         fill_ff    <= '0;
         seq_ff     <= 8'd0;
         open_ff    <= 1'b0;
         started_ff <= 1'b0;
         sub_ff     <= 3'd0;
      end else begin
         left_ff    <= left_in;
         fill_ff    <= fill_in;
         seq_ff     <= seq_in;
         open_ff    <= open_in;
         started_ff <= started_in;
         sub_ff     <= sub_in;
      end
   end

endmodule

`default_nettype wire

### src/flexray_to_canfd_fragmenter_unit.sv
// Channel   | Direction | Handshake            | Transaction
// ----------+-----------+----------------------+------------------------------------------
// req_      | in        | push / full          | header, payload byte or trailer item
// rsp_      | out       | pop / empty          | one CAN-FD chunk byte with chunk marks
//
// The front end classifies one request per cycle while its two-entry command queue has room.
// The back end emits one chunk byte per cycle while a command waits and the output queue has
// room: a payload item gives one or two bytes, a header six (its sequence byte and five
// stream bytes) and a trailer three or four, as a sequence byte falls inside it or not.
// Results pass through a two-entry output queue; a stalled consumer stops the back end first.
// Reset is synchronous; both queues are empty and no frame is open after it.
`default_nettype none

module flexray_to_canfd_fragmenter_unit
   import fr2cf_pkg::*;
#(
   parameter int CHUNK_BYTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_mode,
   input  wire logic        req_startup_flag,
   input  wire logic        req_sync_flag,
   input  wire logic        req_null_flag,
   input  wire logic        req_preamble_flag,
   input  wire logic        req_reserved_flag,
   input  wire logic [10:0] req_frame_ident,
   input  wire logic [6:0]  req_payload_words,
   input  wire logic [10:0] req_header_check,
   input  wire logic [5:0]  req_cycle_number,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [23:0] req_trailer_check,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_chunk_start,
   output logic [3:0]       rsp_chunk_dlc,
   output logic             rsp_chunk_end,
   output logic             rsp_frame_end
);

   logic    accept;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_data, cmd_head;
   logic    res_push, res_full;
   rsp_type res_data, res_head;

   assign accept   = req_push && !cmd_full;
   assign req_full = cmd_full;

   // Front end: classify requests and build commands.
   fr2cf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_mode),
      .startup_flag  (req_startup_flag),
      .sync_flag     (req_sync_flag),
      .null_flag     (req_null_flag),
      .preamble_flag (req_preamble_flag),
      .reserved_flag (req_reserved_flag),
      .frame_ident   (req_frame_ident),
      .payload_words (req_payload_words),
      .header_check  (req_header_check),
      .cycle_number  (req_cycle_number),
      .data_byte     (req_data_byte),
      .trailer_check (req_trailer_check),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_data)
   );

   // Command queue between the front and back ends.
   fr2cf_queue #(.WIDTH($bits(cmd_type))) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   // Back end: cut the byte stream into chunks.
   fr2cf_back #(.CHUNK_BYTES(CHUNK_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_data  (res_data)
   );

   // Output queue toward the consumer.
   fr2cf_queue #(.WIDTH($bits(rsp_type))) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (res_head)
   );

   assign rsp_out_byte    = res_head.out_byte;
   assign rsp_chunk_start = res_head.chunk_start;
   assign rsp_chunk_dlc   = res_head.chunk_dlc;
   assign rsp_chunk_end   = res_head.chunk_end;
   assign rsp_frame_end   = res_head.frame_end;

endmodule

`default_nettype wire

### src/fr2cf_checker.sv
`default_nettype none

module fr2cf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_empty,
   input wire logic       rsp_chunk_start,
   input wire logic [3:0] rsp_chunk_dlc,
   input wire logic       rsp_chunk_end,
   input wire logic       rsp_frame_end
);

   // The queue comes out of reset empty.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // A sequence byte never closes a chunk or a frame.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_chunk_start) |-> (!rsp_chunk_end && !rsp_frame_end))
      else $error("sequence byte carries end marks");

   // The end of a frame always closes its chunk.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_chunk_end)
      else $error("frame end without chunk end");

   // A DLC appears only on a sequence byte, and a chunk holds at least two bytes.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_chunk_start ? (rsp_chunk_dlc >= 4'd2) : (rsp_chunk_dlc == 4'd0)))
      else $error("chunk DLC misplaced or too small");

endmodule

bind flexray_to_canfd_fragmenter_unit fr2cf_checker u_fr2cf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_chunk_start (rsp_chunk_start),
   .rsp_chunk_dlc   (rsp_chunk_dlc),
   .rsp_chunk_end   (rsp_chunk_end),
   .rsp_frame_end   (rsp_frame_end)
);

`default_nettype wire
